// File: rtl/core/planar_image_rle_decoder_core_defines.svh
// Assertion macros for the planar image run-length decoder core.
// Included by the top level; no other dependencies.
`ifndef PLANAR_IMAGE_RLE_DECODER_CORE_DEFINES_SVH
`define PLANAR_IMAGE_RLE_DECODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent and consequent in the same cycle.
`define PRLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Consequent in the cycle after the antecedent.
`define PRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PRLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/prle_pkg.sv
// Shared types and constants of the planar image run-length decoder.
// No dependencies; imported by every module of the core.
package prle_pkg;

    localparam int MAX_LINE_BYTES_DEF = 4096;
    localparam int MAX_PLANES_DEF     = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);

    localparam int OUT_DATA_W = 56;

    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_ONES  = 8'hFF;
    localparam logic [7:0] LEN_MASK   = 8'h7F;
    localparam logic [7:0] BIT_STRING = 8'h80;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PATTERN_LENGTH = 2'd0;
    localparam t_cfg_idx CFG_LINE_BYTES     = 2'd1;
    localparam t_cfg_idx CFG_PLANE_COUNT    = 2'd2;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT   = 2'd3;

    typedef struct packed {
        logic [7:0]  pattern_length;
        logic [12:0] line_bytes;
        logic [3:0]  plane_count;
        logic [15:0] image_height;
    } t_cfg;

    // One decoded byte's worth of work: a write and an optional row copy.
    typedef struct packed {
        logic [2:0]  plane;
        logic [15:0] row;
        logic [12:0] column;
        logic [7:0]  value;
        logic [7:0]  count;
        logic [7:0]  stride;
        logic        copy_valid;
        logic [7:0]  copy_count;
        logic        done;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_ent;

endpackage

// File: rtl/core/prle_front.sv
// Front end: accepts compressed bytes, runs the line decoder state machine
// and pushes write/copy commands into the queue. Depends on prle_pkg.
module prle_front #(
    parameter int MAX_LINE_BYTES = prle_pkg::MAX_LINE_BYTES_DEF,
    parameter int MAX_PLANES     = prle_pkg::MAX_PLANES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  prle_pkg::t_cfg i_cfg,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_start,
    input  logic           i_q_full,
    output prle_pkg::t_q_ent o_push
);
    import prle_pkg::*;

    localparam int LW = $clog2(MAX_LINE_BYTES);
    localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CW = ((LW > 8) ? LW : 8) + 1;
    localparam int SW = ((CW > 16) ? CW : 16) + 1;

    localparam logic [3:0] PH_LINE_START = 4'd0;
    localparam logic [3:0] PH_HDR1       = 4'd1;
    localparam logic [3:0] PH_HDR2       = 4'd2;
    localparam logic [3:0] PH_HDR3       = 4'd3;
    localparam logic [3:0] PH_OPCODE     = 4'd4;
    localparam logic [3:0] PH_PAT_COUNT  = 4'd5;
    localparam logic [3:0] PH_PAT_BYTES  = 4'd6;
    localparam logic [3:0] PH_BITS_COUNT = 4'd7;
    localparam logic [3:0] PH_BITS_DATA  = 4'd8;

    logic [3:0]    r_phase,  n_phase,  cur_phase;
    logic [PW-1:0] r_plane,  n_plane,  cur_plane;
    logic [15:0]   r_row,    n_row,    cur_row;
    logic [CW-1:0] r_pos,    n_pos,    cur_pos;
    logic [7:0]    r_rep,    n_rep,    cur_rep;
    logic [7:0]    r_run,    n_run,    cur_run;
    logic [7:0]    r_preps,  n_preps,  cur_preps;
    logic [7:0]    r_poff,   n_poff,   cur_poff;
    logic [LW-1:0] r_pstart, n_pstart, cur_pstart;

    logic [LW:0]   eff_line;
    logic [PW:0]   eff_planes;
    logic          accept;

    logic          w_valid;
    logic [CW-1:0] w_col;
    logic [7:0]    w_val, w_cnt, w_stride;
    logic          copy_valid;
    logic [7:0]    copy_cnt;
    logic          done;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // A start flag restarts the decoder before its own byte is taken.
    always_comb begin
        if (i_start) begin
            cur_phase  = PH_LINE_START;
            cur_plane  = '0;
            cur_row    = '0;
            cur_pos    = '0;
            cur_rep    = 8'd1;
            cur_run    = '0;
            cur_preps  = '0;
            cur_poff   = '0;
            cur_pstart = '0;
        end else begin
            cur_phase  = r_phase;
            cur_plane  = r_plane;
            cur_row    = r_row;
            cur_pos    = r_pos;
            cur_rep    = r_rep;
            cur_run    = r_run;
            cur_preps  = r_preps;
            cur_poff   = r_poff;
            cur_pstart = r_pstart;
        end
    end

    always_comb begin
        if (i_cfg.line_bytes == '0) begin
            eff_line = (LW+1)'(1);
        end else if (i_cfg.line_bytes > MAX_LINE_BYTES) begin
            eff_line = (LW+1)'(MAX_LINE_BYTES);
        end else begin
            eff_line = (LW+1)'(i_cfg.line_bytes);
        end
        if (i_cfg.plane_count == '0) begin
            eff_planes = (PW+1)'(1);
        end else if (i_cfg.plane_count > MAX_PLANES) begin
            eff_planes = (PW+1)'(MAX_PLANES);
        end else begin
            eff_planes = (PW+1)'(i_cfg.plane_count);
        end
    end

    always_comb begin
        logic          do_opc;
        logic          do_pc;
        logic [7:0]    pc_val;
        logic          chk;
        logic [SW-1:0] end_pos;
        logic [7:0]    solid_len;
        logic [8:0]    off1;
        logic [15:0]   prod;
        logic [7:0]    run1;
        logic [7:0]    rr;
        logic [16:0]   row1;
        logic [16:0]   next_row;
        logic [15:0]   avail;
        logic [7:0]    extra;
        logic [PW:0]   plane1;

        n_phase  = cur_phase;
        n_plane  = cur_plane;
        n_row    = cur_row;
        n_pos    = cur_pos;
        n_rep    = cur_rep;
        n_run    = cur_run;
        n_preps  = cur_preps;
        n_poff   = cur_poff;
        n_pstart = cur_pstart;

        w_valid    = 1'b0;
        w_col      = cur_pos;
        w_val      = BYTE_ZERO;
        w_cnt      = '0;
        w_stride   = 8'd1;
        copy_valid = 1'b0;
        copy_cnt   = '0;
        done       = 1'b0;

        do_opc    = 1'b0;
        do_pc     = 1'b0;
        pc_val    = i_byte;
        chk       = 1'b0;
        end_pos   = SW'(cur_pos);
        solid_len = i_byte & LEN_MASK;
        off1      = {1'b0, cur_poff} + 9'd1;
        prod      = cur_preps * i_cfg.pattern_length;
        run1      = (cur_run != '0) ? cur_run - 8'd1 : '0;

        unique case (cur_phase)
            PH_LINE_START: begin
                if (i_byte == BYTE_ZERO) n_phase = PH_HDR1;
                else do_opc = 1'b1;
            end
            PH_HDR1: begin
                if (i_byte == BYTE_ZERO) n_phase = PH_HDR2;
                else do_pc = 1'b1;
            end
            PH_HDR2: begin
                if (i_byte == BYTE_ONES) begin
                    n_phase = PH_HDR3;
                end else begin
                    // Not a header after all: a pattern run of zero repeats
                    // whose first pattern byte is this one.
                    n_preps  = '0;
                    n_poff   = '0;
                    n_pstart = LW'(cur_pos);
                    if (i_cfg.pattern_length == '0) begin
                        do_opc = 1'b1;
                    end else if (i_cfg.pattern_length == 8'd1) begin
                        n_poff  = 8'd1;
                        n_phase = PH_OPCODE;
                    end else begin
                        n_poff  = 8'd1;
                        n_phase = PH_PAT_BYTES;
                    end
                end
            end
            PH_HDR3: begin
                n_rep   = (i_byte == BYTE_ZERO) ? 8'd1 : i_byte;
                n_phase = PH_OPCODE;
            end
            PH_OPCODE: begin
                do_opc = 1'b1;
            end
            PH_PAT_COUNT: begin
                do_pc = 1'b1;
            end
            PH_PAT_BYTES: begin
                if (cur_preps != '0) begin
                    w_valid  = 1'b1;
                    w_col    = CW'(cur_pstart) + CW'(cur_poff);
                    w_val    = i_byte;
                    w_cnt    = cur_preps;
                    w_stride = i_cfg.pattern_length;
                end
                n_poff = off1[7:0];
                if (off1 >= {1'b0, i_cfg.pattern_length}) begin
                    end_pos = SW'(cur_pstart) + SW'(prod);
                    n_pos   = CW'(end_pos);
                    n_phase = PH_OPCODE;
                    chk     = (cur_preps != '0);
                end
            end
            PH_BITS_COUNT: begin
                n_run   = i_byte;
                n_phase = (i_byte == BYTE_ZERO) ? PH_OPCODE : PH_BITS_DATA;
            end
            PH_BITS_DATA: begin
                w_valid  = 1'b1;
                w_col    = cur_pos;
                w_val    = i_byte;
                w_cnt    = 8'd1;
                w_stride = 8'd1;
                end_pos  = SW'(cur_pos) + SW'(1);
                n_pos    = CW'(end_pos);
                n_run    = run1;
                if (run1 == '0) begin
                    n_phase = PH_OPCODE;
                    chk     = 1'b1;
                end
            end
            default: begin
                n_phase  = PH_LINE_START;
                n_plane  = '0;
                n_row    = '0;
                n_pos    = '0;
                n_rep    = 8'd1;
                n_run    = '0;
                n_preps  = '0;
                n_poff   = '0;
                n_pstart = '0;
            end
        endcase

        if (do_pc) begin
            n_preps  = pc_val;
            n_poff   = '0;
            n_pstart = LW'(cur_pos);
            n_phase  = (i_cfg.pattern_length == '0) ? PH_OPCODE : PH_PAT_BYTES;
        end

        if (do_opc) begin
            if (i_byte == BYTE_ZERO) begin
                n_phase = PH_PAT_COUNT;
            end else if (i_byte == BIT_STRING) begin
                n_phase = PH_BITS_COUNT;
            end else begin
                w_valid  = 1'b1;
                w_col    = cur_pos;
                w_val    = i_byte[7] ? BYTE_ONES : BYTE_ZERO;
                w_cnt    = solid_len;
                w_stride = 8'd1;
                end_pos  = SW'(cur_pos) + SW'(solid_len);
                n_pos    = CW'(end_pos);
                n_phase  = PH_OPCODE;
                chk      = 1'b1;
            end
        end

        // Line end: optional row copy, then next plane or next row group.
        rr       = (cur_rep == '0) ? 8'd1 : cur_rep;
        row1     = {1'b0, cur_row} + 17'd1;
        next_row = {1'b0, cur_row} + 17'(rr);
        avail    = i_cfg.image_height - 16'd1 - cur_row;
        extra    = rr - 8'd1;
        if ({8'b0, extra} > avail) extra = avail[7:0];
        plane1   = {1'b0, cur_plane} + (PW+1)'(1);

        if (chk && (end_pos >= SW'(eff_line))) begin
            if (row1 < {1'b0, i_cfg.image_height}) begin
                copy_valid = (extra != '0);
                copy_cnt   = extra;
            end
            n_pos   = '0;
            n_phase = PH_LINE_START;
            if (plane1 >= eff_planes) begin
                n_plane = '0;
                n_rep   = 8'd1;
                if (next_row >= {1'b0, i_cfg.image_height}) begin
                    n_row = '0;
                    done  = 1'b1;
                end else begin
                    n_row = next_row[15:0];
                end
            end else begin
                n_plane = plane1[PW-1:0];
            end
        end
    end

    always_comb begin
        o_push.valid          = accept && w_valid;
        o_push.cmd.plane      = 3'(cur_plane);
        o_push.cmd.row        = cur_row;
        o_push.cmd.column     = 13'(w_col);
        o_push.cmd.value      = w_val;
        o_push.cmd.count      = w_cnt;
        o_push.cmd.stride     = w_stride;
        o_push.cmd.copy_valid = copy_valid;
        o_push.cmd.copy_count = copy_cnt;
        o_push.cmd.done       = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LINE_START;
            r_plane  <= '0;
            r_row    <= '0;
            r_pos    <= '0;
            r_rep    <= 8'd1;
            r_run    <= '0;
            r_preps  <= '0;
            r_poff   <= '0;
            r_pstart <= '0;
        end else if (accept) begin
            r_phase  <= n_phase;
            r_plane  <= n_plane;
            r_row    <= n_row;
            r_pos    <= n_pos;
            r_rep    <= n_rep;
            r_run    <= n_run;
            r_preps  <= n_preps;
            r_poff   <= n_poff;
            r_pstart <= n_pstart;
        end
    end

endmodule

// File: rtl/core/prle_fifo.sv
// Short command queue between the decoder front end and the descriptor
// back end. Depends on prle_pkg.
module prle_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prle_pkg::t_q_ent i_push,
    input  logic             i_pop,
    output prle_pkg::t_q_ent o_head,
    output logic             o_full
);
    import prle_pkg::*;

    t_cmd           r_mem [QUEUE_DEPTH];
    logic [QPW-1:0] r_wptr, r_rptr;
    logic [QPW:0]   r_cnt;
    logic           do_pop;

    assign o_full      = (r_cnt == (QPW+1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rptr];
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push.valid) r_wptr <= r_wptr + QPW'(1);
            if (do_pop)       r_rptr <= r_rptr + QPW'(1);
            if (i_push.valid && !do_pop)      r_cnt <= r_cnt + (QPW+1)'(1);
            else if (!i_push.valid && do_pop) r_cnt <= r_cnt - (QPW+1)'(1);
        end
    end

endmodule

// File: rtl/core/prle_back.sv
// Back end: expands queued commands into output descriptors, a write and
// then an optional row copy, through an output register. Depends on prle_pkg.
module prle_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  prle_pkg::t_q_ent                   i_head,
    output logic                               o_pop,
    input  logic                               i_m_ready,
    output logic                               o_m_valid,
    output logic [prle_pkg::OUT_DATA_W-1:0]    o_m_data,
    output logic                               o_m_kind,
    output logic                               o_m_last
);
    import prle_pkg::*;

    logic r_valid;
    logic r_second;
    t_cmd r_cmd;
    logic fire;
    logic last_beat;
    logic load;

    assign fire      = r_valid && i_m_ready;
    assign last_beat = r_second || !r_cmd.copy_valid;
    assign load      = !r_valid || (fire && last_beat);
    assign o_pop     = load && i_head.valid;

    always_ff @(posedge i_clk) begin
        if (load && i_head.valid) r_cmd <= i_head.cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= i_head.valid;
            r_second <= 1'b0;
        end else if (fire) begin
            r_second <= 1'b1;
        end
    end

    assign o_m_valid = r_valid;
    assign o_m_kind  = r_second;
    assign o_m_last  = r_second ? r_cmd.done : (r_cmd.done && !r_cmd.copy_valid);

    always_comb begin
        if (r_second) begin
            o_m_data = {8'd0, r_cmd.copy_count, 8'd0, 13'd0, r_cmd.row, r_cmd.plane};
        end else begin
            o_m_data = {r_cmd.stride, r_cmd.count, r_cmd.value, r_cmd.column,
                        r_cmd.row, r_cmd.plane};
        end
    end

endmodule

// File: rtl/core/planar_image_rle_decoder_core.sv
// Planar image run-length decoder core: compressed bytes in, write and row copy
// descriptors out. Throughput is one compressed byte per cycle unless the command queue
// is full, set by the decoder state machine in the front end. A byte's write descriptor
// passes the queue and the back end's output register; a row copy is the next beat.
// Reset is synchronous, active low: decoder state, queue and output stage clear
// and the configuration registers return to their defaults.
`include "planar_image_rle_decoder_core_defines.svh"
module planar_image_rle_decoder_core #(
    parameter int MAX_LINE_BYTES = prle_pkg::MAX_LINE_BYTES_DEF,
    parameter int MAX_PLANES     = prle_pkg::MAX_PLANES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    // Compressed byte stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_axis_tuser,   // [0] start_image
    // Descriptor stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [prle_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // [2:0] plane, [18:3] row, [31:19] column, [39:32] value, [47:40] count,
    // [55:48] stride
    output logic [0:0]  m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast    // image_done
);
    import prle_pkg::*;

    // Configuration registers. They are to be written by the user only while the core is idle;
    // the block itself does not enforce this. The front end reads the current values on every byte.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_length <= 8'd2;
            r_cfg.line_bytes     <= 13'd80;
            r_cfg.plane_count    <= 4'd1;
            r_cfg.image_height   <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_wdata[7:0];
                CFG_LINE_BYTES:     r_cfg.line_bytes     <= i_cfg_wdata[12:0];
                CFG_PLANE_COUNT:    r_cfg.plane_count    <= i_cfg_wdata[3:0];
                CFG_IMAGE_HEIGHT:   r_cfg.image_height   <= i_cfg_wdata;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    // The front end decodes one byte per transaction and pushes at most one
    // command; it stalls only while the command queue is full.
    t_q_ent push;
    t_q_ent head;
    logic   q_full;
    logic   pop;
    logic   out_kind;

    prle_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_PLANES     (MAX_PLANES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_start    (s_axis_tuser[0]),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    // The queue absorbs output stalls and the extra beat of a row copy.
    prle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full)
    );

    // The back end turns each command into one or two descriptor transactions.
    prle_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .o_pop     (pop),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_m_data  (m_axis_tdata),
        .o_m_kind  (out_kind),
        .o_m_last  (m_axis_tlast)
    );

    assign m_axis_tuser[0] = out_kind;

    // Short names for the output handshake and the plane and row bits, used by the
    // checks below. The kind bit is only ever high while the output is valid.
    logic        out_fire;
    logic [18:0] out_loc;

    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign out_loc  = m_axis_tdata[18:0];

    // A copy beat is only ever shown right after its write beat has gone out.
    `PRLE_ASSERT_IMPLY(a_copy_after_write, i_clk, i_rst_n, $rose(out_kind), $past(out_fire))
    // A copy carries the plane and row of the write that precedes it.
    `PRLE_ASSERT_IMPLY(a_copy_same_row, i_clk, i_rst_n, $rose(out_kind), out_loc == $past(out_loc))
    // The front end never pushes into a full queue.
    `PRLE_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, push.valid, !q_full)

endmodule

// File: tb/rle_descriptor_checker.sv
`timescale 1ns / 1ps
// Descriptor checker for the planar image run-length decoder core: mirrors the decoder state,
// predicts descriptors per accepted byte and compares them. Depends on prle_pkg only.
module rle_descriptor_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  prle_pkg::t_cfg_idx              i_cfg_addr,
    input  logic [15:0]                     i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                      s_axis_tuser,   // [0] start_image
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [2:0] plane, [18:3] row, [31:19] column, [39:32] value, [47:40] count, [55:48] stride
    input  logic [prle_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [0:0]                      m_axis_tuser,   // [0] kind
    input  logic                            m_axis_tlast,
    output int                              o_mismatches,
    output int                              o_pending
);
    import prle_pkg::*;

    typedef enum logic [3:0] {
        DEC_LINE_START, DEC_ONE_ZERO, DEC_TWO_ZEROS, DEC_REPEAT, DEC_OPCODE,
        DEC_PAT_COUNT, DEC_PAT_BYTES, DEC_BITS_COUNT, DEC_BITS_DATA
    } t_dec_phase;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_COPY  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [2:0]  plane;
        logic [15:0] row;
        logic [12:0] column;
        logic [7:0]  value;
        logic [7:0]  count;
        logic [7:0]  stride;
        logic        done;
    } t_desc;

    logic [7:0]  pat_len_reg;
    logic [12:0] line_bytes_reg;
    logic [3:0]  planes_reg;
    logic [15:0] height_reg;

    t_dec_phase  dec_phase;
    int unsigned cur_plane, cur_row, line_pos, row_repeat;
    int unsigned bits_left, pat_reps, pat_offset, pat_base;

    t_desc expected_desc[$];
    t_desc step_desc[2];
    int    step_n;

    function automatic int unsigned line_limit();
        if (line_bytes_reg == 0) return 1;
        if (line_bytes_reg > MAX_LINE_BYTES_DEF) return MAX_LINE_BYTES_DEF;
        return line_bytes_reg;
    endfunction

    function automatic int unsigned plane_limit();
        if (planes_reg == 0) return 1;
        if (planes_reg > MAX_PLANES_DEF) return MAX_PLANES_DEF;
        return planes_reg;
    endfunction

    task automatic restart_image();
        dec_phase  = DEC_LINE_START;
        cur_plane  = 0;
        cur_row    = 0;
        line_pos   = 0;
        row_repeat = 1;
        bits_left  = 0;
        pat_reps   = 0;
        pat_offset = 0;
        pat_base   = 0;
    endtask

    task automatic add_desc(input logic kind, input int unsigned col, input int unsigned val,
                            input int unsigned cnt, input int unsigned stride);
        t_desc d;
        d.kind   = kind;
        d.plane  = cur_plane[2:0];
        d.row    = cur_row[15:0];
        d.column = col[12:0];
        d.value  = val[7:0];
        d.count  = cnt[7:0];
        d.stride = stride[7:0];
        d.done   = 1'b0;
        step_desc[step_n] = d;
        step_n++;
    endtask

    // End of a plane line: optional row copy, then plane and row bookkeeping.
    task automatic close_line();
        int unsigned rr, avail, extra, next_row;
        rr = (row_repeat == 0) ? 1 : row_repeat;
        if (cur_row + 1 < height_reg) begin
            avail = height_reg - 1 - cur_row;
            extra = rr - 1;
            if (extra > avail) extra = avail;
            if (extra > 0) add_desc(KIND_COPY, 0, 0, extra, 0);
        end
        line_pos  = 0;
        dec_phase = DEC_LINE_START;
        cur_plane++;
        if (cur_plane >= plane_limit()) begin
            cur_plane  = 0;
            next_row   = cur_row + rr;
            row_repeat = 1;
            if (next_row >= height_reg) begin
                cur_row = 0;
                if (step_n > 0) step_desc[step_n-1].done = 1'b1;
            end else begin
                cur_row = next_row;
            end
        end
    endtask

    task automatic end_opcode(input logic advanced);
        dec_phase = DEC_OPCODE;
        if (advanced && line_pos >= line_limit()) close_line();
    endtask

    task automatic take_opcode(input logic [7:0] b);
        int unsigned len;
        if (b == BYTE_ZERO) begin
            dec_phase = DEC_PAT_COUNT;
        end else if (b == BIT_STRING) begin
            dec_phase = DEC_BITS_COUNT;
        end else begin
            len = b & LEN_MASK;
            add_desc(KIND_WRITE, line_pos, ((b & BIT_STRING) != 0) ? BYTE_ONES : BYTE_ZERO,
                     len, 1);
            line_pos += len;
            end_opcode(1'b1);
        end
    endtask

    task automatic take_pat_count(input logic [7:0] c);
        pat_reps   = c;
        pat_offset = 0;
        pat_base   = line_pos;
        if (pat_len_reg == 0) end_opcode(1'b0);
        else dec_phase = DEC_PAT_BYTES;
    endtask

    task automatic take_pat_byte(input logic [7:0] b);
        logic adv;
        adv = (pat_reps > 0);
        if (adv) add_desc(KIND_WRITE, pat_base + pat_offset, b, pat_reps, pat_len_reg);
        pat_offset++;
        if (pat_offset >= pat_len_reg) begin
            line_pos = pat_base + pat_reps * pat_len_reg;
            end_opcode(adv);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic start);
        int k;
        step_n = 0;
        if (start) restart_image();
        case (dec_phase)
            DEC_LINE_START: begin
                if (b == BYTE_ZERO) dec_phase = DEC_ONE_ZERO;
                else take_opcode(b);
            end
            DEC_ONE_ZERO: begin
                if (b == BYTE_ZERO) dec_phase = DEC_TWO_ZEROS;
                else take_pat_count(b);
            end
            DEC_TWO_ZEROS: begin
                // Without the FF marker this is a pattern run of zero repeats.
                if (b == BYTE_ONES) begin
                    dec_phase = DEC_REPEAT;
                end else begin
                    take_pat_count(BYTE_ZERO);
                    if (dec_phase == DEC_PAT_BYTES) take_pat_byte(b);
                    else take_opcode(b);
                end
            end
            DEC_REPEAT: begin
                row_repeat = (b == BYTE_ZERO) ? 1 : b;
                dec_phase  = DEC_OPCODE;
            end
            DEC_OPCODE:    take_opcode(b);
            DEC_PAT_COUNT: take_pat_count(b);
            DEC_PAT_BYTES: take_pat_byte(b);
            DEC_BITS_COUNT: begin
                bits_left = b;
                if (b == BYTE_ZERO) end_opcode(1'b0);
                else dec_phase = DEC_BITS_DATA;
            end
            DEC_BITS_DATA: begin
                add_desc(KIND_WRITE, line_pos, b, 1, 1);
                line_pos++;
                if (bits_left > 0) bits_left--;
                if (bits_left == 0) end_opcode(1'b1);
            end
            default: restart_image();
        endcase
        for (k = 0; k < step_n; k++) expected_desc.push_back(step_desc[k]);
    endtask

    task automatic flag_mismatch(input string what, input t_desc exp, input t_desc got);
        if (o_mismatches < 10) begin
            $display("%0t %s: expected kind=%0d plane=%0d row=%0d col=%0d val=%02h cnt=%0d",
                     $realtime, what, exp.kind, exp.plane, exp.row, exp.column, exp.value,
                     exp.count);
            $display("    stride=%0d done=%0d / got kind=%0d plane=%0d row=%0d col=%0d",
                     exp.stride, exp.done, got.kind, got.plane, got.row, got.column);
            $display("    val=%02h cnt=%0d stride=%0d done=%0d",
                     got.value, got.count, got.stride, got.done);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_desc got, exp;
        if (!i_rst_n) begin
            pat_len_reg    = 8'd2;
            line_bytes_reg = 13'd80;
            planes_reg     = 4'd1;
            height_reg     = 16'd1;
            restart_image();
            expected_desc.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PATTERN_LENGTH: pat_len_reg    = i_cfg_wdata[7:0];
                    CFG_LINE_BYTES:     line_bytes_reg = i_cfg_wdata[12:0];
                    CFG_PLANE_COUNT:    planes_reg     = i_cfg_wdata[3:0];
                    CFG_IMAGE_HEIGHT:   height_reg     = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind   = m_axis_tuser[0];
                got.plane  = m_axis_tdata[2:0];
                got.row    = m_axis_tdata[18:3];
                got.column = m_axis_tdata[31:19];
                got.value  = m_axis_tdata[39:32];
                got.count  = m_axis_tdata[47:40];
                got.stride = m_axis_tdata[55:48];
                got.done   = m_axis_tlast;
                if (expected_desc.size() == 0) begin
                    flag_mismatch("descriptor with nothing expected", '0, got);
                end else begin
                    exp = expected_desc.pop_front();
                    if (got.kind !== exp.kind || got.plane !== exp.plane ||
                        got.row !== exp.row || got.column !== exp.column ||
                        got.value !== exp.value || got.count !== exp.count ||
                        got.stride !== exp.stride || got.done !== exp.done)
                        flag_mismatch("descriptor differs", exp, got);
                end
            end
            if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser[0]);
        end
        o_pending = expected_desc.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the planar image run-length decoder core: clock, reset, configuration
// writes, compressed byte stimulus and the verdict. Needs prle_pkg, the core and the checker.
module testbench;
    import prle_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_PERCENT  = 33;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    t_cfg_idx              i_cfg_addr    = CFG_PATTERN_LENGTH;
    logic [15:0]           i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    int mismatches;
    int pending;
    int cycle_count = 0;
    int sent        = 0;

    // When idle_on is low, neither side inserts gaps or stalls.
    bit idle_on = 1'b1;
    // Set when the next line should restart the image so the generator's view of the
    // line position lines up with the decoder again.
    bit resync  = 1'b1;

    // Shadow of the configuration, used only to shape the stimulus.
    logic [7:0]  cur_plen = 8'd2;
    logic [12:0] cur_lb   = 13'd80;

    planar_image_rle_decoder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rle_descriptor_checker descriptor_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The descriptor receiver stalls about a third of the cycles while idling is on.
    always @(posedge i_clk) begin
        m_axis_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("planar_image_rle_decoder_core: mismatch");
            $finish;
        end
    end

    function automatic int unsigned line_limit();
        if (cur_lb == 0) return 1;
        if (cur_lb > MAX_LINE_BYTES_DEF) return MAX_LINE_BYTES_DEF;
        return cur_lb;
    endfunction

    // Offers one compressed byte, with random gaps before it, and returns right after the
    // edge at which the transaction completed. tvalid stays high so back-to-back bytes
    // flow without a bubble.
    task automatic send_byte(input logic [7:0] b, input logic start);
        s_axis_tdata <= b;
        s_axis_tuser <= start;
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    // Holds the sender off until every predicted descriptor has arrived, then lets the
    // pipeline run empty before returning, since the last bytes may have caused none.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all four registers on consecutive cycles. Bits above a register's width carry
    // random junk, which the block must ignore.
    task automatic write_config(input logic [7:0] plen, input logic [12:0] lb,
                                input logic [3:0] pc, input logic [15:0] ih);
        cur_plen = plen;
        cur_lb   = lb;
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_PATTERN_LENGTH;
        i_cfg_wdata <= {8'($urandom_range(0, 255)), plen};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_LINE_BYTES;
        i_cfg_wdata <= {3'($urandom_range(0, 7)), lb};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_PLANE_COUNT;
        i_cfg_wdata <= {12'($urandom_range(0, 4095)), pc};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_IMAGE_HEIGHT;
        i_cfg_wdata <= ih;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // One plane line of compressed data. Most lines are well formed: an optional repeat
    // header, then solid runs, bit strings and pattern runs until the line is full. A few
    // are plain noise, after which the next line restarts the image. A line stops early
    // once the phase has sent its share of bytes; the next phase restarts the image.
    task automatic gen_line(input int budget);
        int unsigned lim, pos, room, len, n, k, reps, r;
        logic [7:0] op;
        logic st;
        lim = line_limit();
        st = resync || ($urandom_range(0, 99) < 2);
        resync = 1'b0;
        if ($urandom_range(0, 99) < 8) begin
            n = $urandom_range(2, 10);
            for (k = 0; k < n; k++) begin
                send_byte(8'($urandom_range(0, 255)), st);
                st = 1'b0;
            end
            resync = 1'b1;
        end else begin
            if ($urandom_range(0, 99) < 50) begin
                r = $urandom_range(0, 99);
                reps = (r < 10) ? 255 : (r < 20) ? 0 : $urandom_range(1, 4);
                send_byte(BYTE_ZERO, st);
                send_byte(BYTE_ZERO, 1'b0);
                send_byte(BYTE_ONES, 1'b0);
                send_byte(reps[7:0], 1'b0);
                st = 1'b0;
            end
            pos = 0;
            while (pos < lim && sent < budget) begin
                room = lim - pos;
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    // Solid run; now and then longer than what is left of the line.
                    if (room > 127 || $urandom_range(0, 99) < 20) len = $urandom_range(1, 127);
                    else len = $urandom_range(1, room);
                    op = len[7:0];
                    op[7] = 1'($urandom_range(0, 1));
                    send_byte(op, st);
                    pos += len;
                end else if (r < 70) begin
                    n = $urandom_range(0, (room < 8) ? room : 8);
                    send_byte(BIT_STRING, st);
                    send_byte(n[7:0], 1'b0);
                    for (k = 0; k < n; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
                    pos += n;
                end else begin
                    reps = ($urandom_range(0, 99) < 5) ? 255 : $urandom_range(0, 3);
                    send_byte(BYTE_ZERO, st);
                    send_byte(reps[7:0], 1'b0);
                    for (k = 0; k < cur_plen; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
                    pos += reps * cur_plen;
                end
                st = 1'b0;
            end
        end
    endtask

    initial begin
        int ph, r;
        int phase_end;
        logic [7:0]  plen;
        logic [12:0] lb;
        logic [3:0]  pc;
        logic [15:0] ih;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed bytes at the reset configuration (pattern length 2, 80-byte lines,
        // one plane, one row). Header with a repeat of zero, which counts as one.
        send_byte(BYTE_ZERO, 1'b1);
        send_byte(BYTE_ZERO, 1'b0);
        send_byte(BYTE_ONES, 1'b0);
        send_byte(BYTE_ZERO, 1'b0);
        // Header lookalike: 00 00 without the FF marker is a zero-repeat pattern run whose
        // first pattern byte is the third byte. Nothing is written.
        send_byte(BYTE_ZERO, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(8'hAA, 1'b0);
        // Empty bit string, then a two-byte bit string.
        send_byte(BIT_STRING, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(BIT_STRING, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        // Pattern run of three repeats.
        send_byte(BYTE_ZERO, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        // Longest solid runs of both fills; each one overruns the line and ends the image.
        send_byte(LEN_MASK, 1'b0);
        send_byte(BYTE_ONES, 1'b0);
        settle();

        // Zero pattern length, and line length and plane count of zero, which clamp to one.
        // A repeat of five on a three-row image copies into only the two rows left.
        write_config(8'd0, 13'd0, 4'd0, 16'd3);
        send_byte(BYTE_ZERO, 1'b1);
        send_byte(BYTE_ZERO, 1'b0);
        send_byte(BYTE_ONES, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(BYTE_ZERO, 1'b0);
        send_byte(8'h07, 1'b0);
        send_byte(8'h85, 1'b0);
        settle();

        // Random phases, each with its own configuration. The first two take the high and
        // low extremes; one phase near the end runs with no gaps and no stalls at all.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                plen = 8'd255;
                lb   = 13'd8191;
                pc   = 4'd15;
                ih   = 16'd65535;
            end else if (ph == 1) begin
                plen = 8'd1;
                lb   = 13'd1;
                pc   = 4'd1;
                ih   = 16'd1;
            end else begin
                r = $urandom_range(0, 99);
                plen = (r < 10) ? 8'd0 : (r < 18) ? 8'($urandom_range(5, 255))
                                                  : 8'($urandom_range(1, 4));
                r = $urandom_range(0, 99);
                lb = (r < 5) ? 13'($urandom_range(4097, 8191)) : (r < 12) ? 13'd0
                                                               : 13'($urandom_range(1, 48));
                pc = ($urandom_range(0, 99) < 30) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 3));
                ih = ($urandom_range(0, 99) < 10) ? 16'($urandom_range(7, 65535))
                                                  : 16'($urandom_range(1, 6));
            end
            write_config(plen, lb, pc, ih);
            idle_on   = (ph != RANDOM_PHASES - 2);
            resync    = 1'b1;
            phase_end = sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (sent < phase_end) gen_line(phase_end);
            settle();
            idle_on = 1'b1;
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("planar_image_rle_decoder_core: match");
        end else begin
            $display("planar_image_rle_decoder_core: mismatch");
        end
        $finish;
    end

endmodule
